[sv/inverted_page_table_fifo_age_defines.svh]
// Assertion macros for the inverted page table block.
// Used by the port checker; no other dependencies.
`ifndef INVERTED_PAGE_TABLE_FIFO_AGE_DEFINES_SVH
`define INVERTED_PAGE_TABLE_FIFO_AGE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IPT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ipt_age_pkg.sv]
// Shared request codes and field types of the inverted page table.
// No dependencies.
package ipt_age_pkg;

    typedef logic [2:0] req_t;

    localparam req_t REQ_ADD        = 3'd0;
    localparam req_t REQ_LOOKUP     = 3'd1;
    localparam req_t REQ_VICTIM_PID = 3'd2;
    localparam req_t REQ_VICTIM_ANY = 3'd3;
    localparam req_t REQ_REMOVE     = 3'd4;
    localparam req_t REQ_REMOVE_PID = 3'd5;
    localparam req_t REQ_READ       = 3'd6;
    localparam req_t REQ_OR_FLAGS   = 3'd7;

    typedef logic [14:0] pid_t;
    typedef logic [31:0] addr_t;
    typedef logic [7:0]  flags_t;
    typedef logic [5:0]  fidx_t;

endpackage

[sv/inverted_page_table_fifo_age.sv]
// Inverted page table with age-based FIFO replacement; top level.
// Depends on ipt_age_pkg.
//
// After reset the table is cleared by a pass over all FRAMES entries, one entry
// per cycle, during which s_ready stays low. Each word is then taken, every
// table entry in its range is scanned through the single read port of the
// entry memory, one per cycle, the read pipeline is drained and the result
// waits in the output register until taken. Add, lookup, victim search and pid
// removal scan the whole table; single-entry requests scan only their entry.
// A request with an index beyond the table skips the scan and gives its error
// word directly. One word is in progress at a time.
module inverted_page_table_fifo_age #(
    parameter int FRAMES     = 64,
    parameter int PAGE_SHIFT = 12,
    parameter int AGE_WIDTH  = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ipt_age_pkg::req_t    s_req_type,
    input  ipt_age_pkg::addr_t   s_phys_addr,
    input  ipt_age_pkg::fidx_t   s_frame_index,
    input  ipt_age_pkg::addr_t   s_virt_addr,
    input  ipt_age_pkg::pid_t    s_proc_id,
    input  ipt_age_pkg::flags_t  s_flag_bits,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_found,
    output logic                 m_error,
    output ipt_age_pkg::fidx_t   m_frame_out,
    output ipt_age_pkg::addr_t   m_phys_addr_out,
    output ipt_age_pkg::addr_t   m_virt_addr_out,
    output logic signed [15:0]   m_proc_id_out,
    output ipt_age_pkg::flags_t  m_flags_out
);
    import ipt_age_pkg::*;

    localparam int IW = $clog2(FRAMES);
    localparam logic [IW-1:0] LAST = IW'(FRAMES - 1);
    localparam logic [31:0] FRAMES32 = 32'(FRAMES);
    localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;
    localparam logic [AGE_WIDTH-1:0] AGE_ONE = AGE_WIDTH'(1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    typedef struct packed {
        logic                 valid;
        pid_t                 owner;
        addr_t                vpage;
        flags_t               flags;
        logic [AGE_WIDTH-1:0] age;
    } entry_t;

    // Entry memory, one read and one write port.
    entry_t          mem [FRAMES];
    entry_t          rdata_reg;
    logic            we;
    logic [IW-1:0]   waddr;
    entry_t          wdata;
    logic [IW-1:0]   raddr;

    logic [2:0]      state_reg, state_next;
    logic [IW-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]   last_reg, last_next;
    logic [IW-1:0]   tgt_reg, tgt_next;
    logic            pv_reg, pv_next;
    logic [IW-1:0]   pidx_reg, pidx_next;
    req_t            op_reg, op_next;
    pid_t            pid_reg, pid_next;
    addr_t           va_reg, va_next;
    flags_t          fl_reg, fl_next;
    logic            hit_reg, hit_next;
    logic            err_reg, err_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [AGE_WIDTH-1:0] best_reg, best_next;
    addr_t           vout_reg, vout_next;
    logic signed [15:0] idout_reg, idout_next;
    flags_t          flout_reg, flout_next;

    logic [31:0]     add_index;
    logic            bad_index;
    logic            own_match;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign add_index = s_phys_addr >> PAGE_SHIFT;
    assign own_match = rdata_reg.valid && (rdata_reg.owner == pid_reg);
    assign raddr     = cnt_reg;

    always_comb begin
        if (s_req_type == REQ_ADD) begin
            bad_index = add_index >= FRAMES32;
        end else if (s_req_type == REQ_REMOVE || s_req_type == REQ_READ ||
                     s_req_type == REQ_OR_FLAGS) begin
            bad_index = 32'(s_frame_index) >= FRAMES32;
        end else begin
            bad_index = 1'b0;
        end
    end

    // Sequencer and per-entry processing of the registered read data.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        tgt_next   = tgt_reg;
        pv_next    = 1'b0;
        pidx_next  = pidx_reg;
        op_next    = op_reg;
        pid_next   = pid_reg;
        va_next    = va_reg;
        fl_next    = fl_reg;
        hit_next   = hit_reg;
        err_next   = err_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        vout_next  = vout_reg;
        idout_next = idout_reg;
        flout_next = flout_reg;
        we         = 1'b0;
        waddr      = pidx_reg;
        wdata      = rdata_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = cnt_reg;
                wdata = '0;
                if (cnt_reg == LAST) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_req_type;
                    pid_next   = s_proc_id;
                    va_next    = s_virt_addr;
                    fl_next    = s_flag_bits;
                    idx_next   = '0;
                    best_next  = '0;
                    vout_next  = '0;
                    idout_next = '0;
                    flout_next = '0;
                    err_next   = bad_index;
                    hit_next   = !bad_index && !(s_req_type == REQ_LOOKUP ||
                                 s_req_type == REQ_VICTIM_PID ||
                                 s_req_type == REQ_VICTIM_ANY);
                    if (s_req_type == REQ_ADD) begin
                        tgt_next = add_index[IW-1:0];
                    end else begin
                        tgt_next = IW'(s_frame_index);
                    end
                    if (s_req_type == REQ_REMOVE || s_req_type == REQ_READ ||
                        s_req_type == REQ_OR_FLAGS) begin
                        cnt_next  = IW'(s_frame_index);
                        last_next = IW'(s_frame_index);
                    end else begin
                        cnt_next  = '0;
                        last_next = LAST;
                    end
                    state_next = bad_index ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                pv_next   = 1'b1;
                pidx_next = cnt_reg;
                if (cnt_reg == last_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase

        // One entry arrives from memory each cycle while a scan runs.
        if (pv_reg) begin
            case (op_reg)
                REQ_ADD: begin
                    we = 1'b1;
                    if (pidx_reg == tgt_reg) begin
                        wdata = '{valid: 1'b1, owner: pid_reg, vpage: va_reg,
                                  flags: fl_reg, age: AGE_ONE};
                    end else if (rdata_reg.valid && rdata_reg.age != AGE_MAX) begin
                        wdata.age = rdata_reg.age + 1'b1;
                    end
                end
                REQ_LOOKUP: begin
                    if (!hit_reg && own_match && rdata_reg.vpage == va_reg) begin
                        hit_next = 1'b1;
                        idx_next = pidx_reg;
                    end
                end
                REQ_VICTIM_PID, REQ_VICTIM_ANY: begin
                    if ((op_reg == REQ_VICTIM_ANY || own_match) &&
                        rdata_reg.age > best_reg) begin
                        hit_next  = 1'b1;
                        idx_next  = pidx_reg;
                        best_next = rdata_reg.age;
                    end
                end
                REQ_REMOVE: begin
                    we    = 1'b1;
                    wdata = '0;
                end
                REQ_REMOVE_PID: begin
                    we    = own_match;
                    wdata = '0;
                end
                REQ_READ: begin
                    vout_next  = rdata_reg.vpage;
                    flout_next = rdata_reg.flags;
                    idout_next = rdata_reg.valid ? $signed({1'b0, rdata_reg.owner})
                                                 : -16'sd1;
                end
                default: begin
                    we          = 1'b1;
                    wdata.flags = rdata_reg.flags | fl_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            pv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pv_reg    <= pv_next;
        end
        last_reg  <= last_next;
        tgt_reg   <= tgt_next;
        pidx_reg  <= pidx_next;
        op_reg    <= op_next;
        pid_reg   <= pid_next;
        va_reg    <= va_next;
        fl_reg    <= fl_next;
        hit_reg   <= hit_next;
        err_reg   <= err_next;
        idx_reg   <= idx_next;
        best_reg  <= best_next;
        vout_reg  <= vout_next;
        idout_reg <= idout_next;
        flout_reg <= flout_next;
    end

    // Result word, held in registers until taken.
    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = (state_reg == ST_OUT);
    assign m_found         = hit_reg;
    assign m_error         = err_reg;
    assign m_frame_out     = (op_reg == REQ_LOOKUP || op_reg == REQ_VICTIM_PID ||
                              op_reg == REQ_VICTIM_ANY) ? 6'(idx_reg) : '0;
    assign m_phys_addr_out = (op_reg == REQ_LOOKUP) ? (32'(idx_reg) << PAGE_SHIFT) : '0;
    assign m_virt_addr_out = vout_reg;
    assign m_proc_id_out   = idout_reg;
    assign m_flags_out     = flout_reg;

endmodule

[sv/ipt_age_checker.sv]
// Port-level checker for the inverted page table and its bind.
// Depends on ipt_age_pkg and inverted_page_table_fifo_age_defines.svh.
`include "inverted_page_table_fifo_age_defines.svh"

module ipt_age_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_found,
    input logic                 m_error,
    input ipt_age_pkg::fidx_t   m_frame_out
);
    import ipt_age_pkg::*;

    // A stalled result word keeps its contents.
    `IPT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_frame_out) && $stable(m_found), "stalled result word changed")
    // An error word never reports success.
    `IPT_ASSERT_NOW(a_err_not_found, aclk, aresetn, m_valid && m_error, !m_found, "error word reports found")
    // No new word is taken while a result waits.
    `IPT_ASSERT_NOW(a_one_word, aclk, aresetn, m_valid, !s_ready, "input taken while result pending")
    // After a word is taken the block does not take another in the next cycle.
    `IPT_ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready, "block not busy after accept")

endmodule

bind inverted_page_table_fifo_age ipt_age_checker u_ipt_age_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_found     (m_found),
    .m_error     (m_error),
    .m_frame_out (m_frame_out)
);

[dv/testbench.sv]
// Self-checking testbench for the inverted page table with age-based replacement.
// Depends on ipt_age_pkg and the inverted_page_table_fifo_age top level; needs no files.
// A scoreboard class predicts each result word from its own copy of the table.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ipt_age_pkg::*;

    localparam int NFRAMES     = 64;
    localparam int PSHIFT      = 12;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        req_t   req;
        addr_t  paddr;
        fidx_t  fidx;
        addr_t  vaddr;
        pid_t   pid;
        flags_t flags;
    } req_word_t;

    typedef struct packed {
        logic               found;
        logic               error;
        fidx_t              frame;
        addr_t              paddr;
        addr_t              vaddr;
        logic signed [15:0] pid;
        flags_t             flags;
    } rsp_word_t;

    // Holds a shadow copy of the table and the responses still owed by the block.
    class ipt_scoreboard;
        bit          vld[NFRAMES];
        pid_t        owner[NFRAMES];
        addr_t       vpage[NFRAMES];
        flags_t      flg[NFRAMES];
        logic [31:0] age[NFRAMES];
        rsp_word_t   owed_q[$];
        int          failures;
        int          checked;
        int          op_count[8];

        function void wipe(int i);
            vld[i] = 0; owner[i] = '0; vpage[i] = '0; flg[i] = '0; age[i] = '0;
        endfunction

        // Apply one accepted request word to the shadow table and queue its response.
        function void note_request(req_word_t w);
            rsp_word_t   r;
            logic [31:0] best;
            logic [31:0] idx;
            r = '0;
            op_count[w.req]++;
            case (w.req)
                REQ_ADD: begin
                    idx = w.paddr >> PSHIFT;
                    if (idx >= NFRAMES) begin
                        r.error = 1'b1;
                    end else begin
                        vld[idx] = 1; owner[idx] = w.pid; vpage[idx] = w.vaddr;
                        flg[idx] = w.flags; age[idx] = '0;
                        for (int i = 0; i < NFRAMES; i++)
                            if (vld[i] && age[i] != '1) age[i]++;
                        r.found = 1'b1;
                    end
                end
                REQ_LOOKUP: begin
                    for (int i = 0; i < NFRAMES; i++) begin
                        if (!r.found && vld[i] && owner[i] == w.pid && vpage[i] == w.vaddr) begin
                            r.found = 1'b1;
                            r.frame = fidx_t'(i);
                            r.paddr = addr_t'(i) << PSHIFT;
                        end
                    end
                end
                REQ_VICTIM_PID, REQ_VICTIM_ANY: begin
                    best = '0;
                    for (int i = 0; i < NFRAMES; i++) begin
                        if (w.req == REQ_VICTIM_PID && !(vld[i] && owner[i] == w.pid)) continue;
                        if (age[i] > best) begin
                            best = age[i]; r.found = 1'b1; r.frame = fidx_t'(i);
                        end
                    end
                end
                REQ_REMOVE: begin
                    wipe(w.fidx);
                    r.found = 1'b1;
                end
                REQ_REMOVE_PID: begin
                    for (int i = 0; i < NFRAMES; i++)
                        if (vld[i] && owner[i] == w.pid) wipe(i);
                    r.found = 1'b1;
                end
                REQ_READ: begin
                    r.vaddr = vpage[w.fidx];
                    r.pid   = vld[w.fidx] ? {1'b0, owner[w.fidx]} : -16'sd1;
                    r.flags = flg[w.fidx];
                    r.found = 1'b1;
                end
                default: begin
                    flg[w.fidx] |= w.flags;
                    r.found = 1'b1;
                end
            endcase
            owed_q.push_back(r);
        endfunction

        // Compare one result word against the oldest owed response.
        function void check_result(rsp_word_t got);
            rsp_word_t exp_r;
            checked++;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result word %p", $realtime, got);
                failures++;
                return;
            end
            exp_r = owed_q.pop_front();
            if (got !== exp_r) begin
                $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
                failures++;
            end
        endfunction
    endclass

    logic   aclk = 0;
    logic   aresetn;
    logic   s_valid, s_ready, m_valid, m_ready;
    req_t   s_req_type;
    addr_t  s_phys_addr, s_virt_addr;
    fidx_t  s_frame_index;
    pid_t   s_proc_id;
    flags_t s_flag_bits;
    rsp_word_t m_word;

    ipt_scoreboard sb = new();
    int send_idle_pct;
    int recv_idle_pct;
    int cycles = 0;
    pid_t pid_pool[4] = '{15'd1, 15'd2, 15'd3, 15'h7FFF};

    inverted_page_table_fifo_age i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_phys_addr     (s_phys_addr),
        .s_frame_index   (s_frame_index),
        .s_virt_addr     (s_virt_addr),
        .s_proc_id       (s_proc_id),
        .s_flag_bits     (s_flag_bits),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_word.found),
        .m_error         (m_word.error),
        .m_frame_out     (m_word.frame),
        .m_phys_addr_out (m_word.paddr),
        .m_virt_addr_out (m_word.vaddr),
        .m_proc_id_out   (m_word.pid),
        .m_flags_out     (m_word.flags)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Random back-pressure on the result channel, and the result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_word);
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one request word, with an optional random gap, and wait for acceptance.
    task automatic send_word(req_word_t w);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid       <= 1;
        s_req_type    <= w.req;
        s_phys_addr   <= w.paddr;
        s_frame_index <= w.fidx;
        s_virt_addr   <= w.vaddr;
        s_proc_id     <= w.pid;
        s_flag_bits   <= w.flags;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(w);
    endtask

    task automatic send_req(req_t rq, addr_t pa, fidx_t fi, addr_t va, pid_t pd, flags_t fl);
        req_word_t w;
        w = '{req: rq, paddr: pa, fidx: fi, vaddr: va, pid: pd, flags: fl};
        send_word(w);
    endtask

    // Hold the sender until every owed response has come back.
    task automatic drain;
        s_valid <= 0;
        @(posedge aclk);
        while (sb.owed_q.size() != 0) @(posedge aclk);
    endtask

    function automatic pid_t pick_pid();
        return ($urandom_range(9) == 0) ? pid_t'($urandom) : pid_pool[$urandom_range(3)];
    endfunction

    // Build a random request; most adds fall inside the table and most lookups reuse a slot's owner and page.
    function automatic req_word_t random_word();
        req_word_t w;
        int        pick;
        int        f;
        w = '{req: REQ_ADD, paddr: $urandom, fidx: fidx_t'($urandom), vaddr: $urandom,
              pid: pick_pid(), flags: flags_t'($urandom)};
        f = $urandom_range(NFRAMES - 1);
        pick = $urandom_range(99);
        if (pick < 30) begin
            w.req = REQ_ADD;
            if ($urandom_range(19) != 0)
                w.paddr = (addr_t'(f) << PSHIFT) | addr_t'($urandom_range(4095));
        end else if (pick < 50) begin
            w.req = REQ_LOOKUP;
            if ($urandom_range(9) < 7) begin
                w.pid = sb.owner[f];
                w.vaddr = sb.vpage[f];
            end
        end else if (pick < 60) begin
            w.req = REQ_VICTIM_PID;
            if ($urandom_range(3) != 0) w.pid = sb.owner[f];
        end else if (pick < 68) begin
            w.req = REQ_VICTIM_ANY;
        end else if (pick < 76) begin
            w.req = REQ_REMOVE;
        end else if (pick < 80) begin
            w.req = REQ_REMOVE_PID;
        end else if (pick < 91) begin
            w.req = REQ_READ;
        end else begin
            w.req = REQ_OR_FLAGS;
        end
        return w;
    endfunction

    initial begin
        s_valid       <= 0;
        s_req_type    <= REQ_ADD;
        s_phys_addr   <= '0;
        s_frame_index <= '0;
        s_virt_addr   <= '0;
        s_proc_id     <= '0;
        s_flag_bits   <= '0;
        m_ready       <= 0;
        aresetn       <= 0;
        send_idle_pct = 34;
        recv_idle_pct = 65;
        repeat (8) @(posedge aclk);
        aresetn <= 1;

        // Directed words: empty table, extremes of the fields and every request kind.
        send_req(REQ_VICTIM_ANY, '0, '0, '0, '0, '0);
        send_req(REQ_READ, '0, 6'd63, '0, '0, '0);
        send_req(REQ_OR_FLAGS, '0, 6'd5, '0, '0, 8'hA5);
        send_req(REQ_READ, '0, 6'd5, '0, '0, '0);
        send_req(REQ_ADD, 32'h0000_0000, '0, 32'h0000_0000, 15'h0000, 8'h00);
        send_req(REQ_ADD, 32'h0003_FFFF, '0, 32'hFFFF_FFFF, 15'h7FFF, 8'hFF);
        send_req(REQ_ADD, 32'h0004_0000, '0, 32'h1234_5678, 15'd9, 8'h0F);
        send_req(REQ_ADD, 32'hFFFF_FFFF, '0, 32'h1234_5678, 15'd9, 8'h0F);
        send_req(REQ_ADD, 32'h0000_5123, '0, 32'hDEAD_B000, 15'h7FFF, 8'h3C);
        send_req(REQ_LOOKUP, '0, '0, 32'hFFFF_FFFF, 15'h7FFF, '0);
        send_req(REQ_LOOKUP, '0, '0, 32'hFFFF_FFFE, 15'h7FFF, '0);
        send_req(REQ_VICTIM_PID, '0, '0, '0, 15'h7FFF, '0);
        send_req(REQ_VICTIM_PID, '0, '0, '0, 15'd44, '0);
        send_req(REQ_VICTIM_ANY, '0, '0, '0, '0, '0);
        send_req(REQ_READ, '0, 6'd63, '0, '0, '0);
        send_req(REQ_OR_FLAGS, '0, 6'd63, '0, '0, 8'h00);
        send_req(REQ_REMOVE, '0, 6'd0, '0, '0, '0);
        send_req(REQ_READ, '0, 6'd0, '0, '0, '0);
        send_req(REQ_VICTIM_ANY, '0, '0, '0, '0, '0);
        send_req(REQ_REMOVE_PID, '0, '0, '0, 15'h7FFF, '0);
        send_req(REQ_READ, '0, 6'd63, '0, '0, '0);
        send_req(REQ_VICTIM_ANY, '0, '0, '0, '0, '0);

        // Random words in three idling phases, each with one full drain.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 65 : 0;
            recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 34 : 0;
            for (int n = 0; n < 430; n++) begin
                if (n == 215) drain();
                send_word(random_word());
            end
        end
        s_valid <= 0;

        // Wait for the last responses, then allow a little extra time.
        @(posedge aclk);
        while (sb.owed_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Checked %0d result words: %0d add, %0d lookup, %0d pid victim, %0d any victim,",
                 sb.checked, sb.op_count[REQ_ADD], sb.op_count[REQ_LOOKUP],
                 sb.op_count[REQ_VICTIM_PID], sb.op_count[REQ_VICTIM_ANY]);
        $display("%0d remove, %0d pid remove, %0d read and %0d flag-or requests; %0d failures.",
                 sb.op_count[REQ_REMOVE], sb.op_count[REQ_REMOVE_PID],
                 sb.op_count[REQ_READ], sb.op_count[REQ_OR_FLAGS], sb.failures);
        if (sb.failures == 0 && sb.owed_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
